// ===== rtl/fcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  // pixel and register field widths
  localparam int PIXEL_BITS = 8;
  localparam int DIM_W      = 11;
  localparam int THR_W      = 8;
  localparam int PCT_W      = 7;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;

  // register defaults and fallbacks
  localparam logic [DIM_W-1:0] RST_WIDTH     = 11'd320;
  localparam logic [DIM_W-1:0] RST_HEIGHT    = 11'd180;
  localparam logic [THR_W-1:0] DEF_THRESHOLD = 8'd24;
  localparam logic [PCT_W-1:0] DEF_PERCENT   = 7'd3;
  localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;

  // ceil division by a hundred that gives the required count
  localparam int CEIL_ADD = 99;
  localparam int PCT_DIV  = 100;

  // cycles from a register write until the required count is settled
  localparam logic [2:0] REQ_LAT = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_DIFF_THRESHOLD  = 3'd2,
    CFG_CHANGED_PERCENT = 3'd3,
    CFG_DETECT_ENABLE   = 3'd4
  } fcd_cfg_idx_t;

  // effective settings seen by the compare stage
  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             enable;
  } fcd_cfg_t;

  // one accepted pixel with its frame context
  typedef struct packed {
    logic [PIXEL_BITS-1:0] px;
    logic                  have_prev;
    logic                  last;
  } fcd_item_t;

endpackage

`default_nettype wire

// ===== rtl/fcd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcd_cfg_regs #(
  parameter int MAX_PIXELS = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcd_pkg::DIM_W-1:0]      cfg_wdata,
  output fcd_pkg::fcd_cfg_t                   cfg,
  output logic [$clog2(MAX_PIXELS+1)-1:0]     total,
  output logic [$clog2(MAX_PIXELS+1)-1:0]     required,
  output logic                                size_wr,
  output logic                                busy
);
  import fcd_pkg::*;

  localparam int PIX_W = $clog2(MAX_PIXELS + 1);
  localparam int X_W   = PIX_W + PCT_W;
  localparam int SH    = X_W + 1;
  localparam longint unsigned RECIP = (longint'(1) << SH) / PCT_DIV;
  localparam logic [SH-1:0] RECIP_V = SH'(RECIP);
  localparam int M_W   = X_W + SH;

  logic [DIM_W-1:0] width_r, height_r;
  logic [THR_W-1:0] thr_r;
  logic [PCT_W-1:0] pct_r;
  logic             en_r;
  logic [2:0]       busy_r;
  logic             known_wr;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [AREA_W-1:0] area;
  logic [PCT_W-1:0]  pct_eff;
  logic [X_W-1:0]    x_nxt;
  logic [M_W-1:0]    mul;
  logic [X_W-1:0]    rem;
  logic [PIX_W-1:0]  req_nxt;

  logic [PIX_W-1:0]  total_r;
  logic [X_W-1:0]    x_r, x_d_r;
  logic [PIX_W-1:0]  q0_r;
  logic [PIX_W-1:0]  req_r;

  // decode of the write index
  always_comb begin
    known_wr = 1'b0;
    size_wr  = 1'b0;
    case (cfg_index)
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
        known_wr = cfg_wr_en;
        size_wr  = cfg_wr_en;
      end
      CFG_DIFF_THRESHOLD, CFG_CHANGED_PERCENT, CFG_DETECT_ENABLE: begin
        known_wr = cfg_wr_en;
      end
      default: begin
        known_wr = 1'b0;
      end
    endcase
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      thr_r    <= DEF_THRESHOLD;
      pct_r    <= DEF_PERCENT;
      en_r     <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:     width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT:    height_r <= cfg_wdata;
        CFG_DIFF_THRESHOLD:  thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_CHANGED_PERCENT: pct_r    <= cfg_wdata[PCT_W-1:0];
        CFG_DETECT_ENABLE:   en_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // hold-off while the required count settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= REQ_LAT;
    end else if (known_wr) begin
      busy_r <= REQ_LAT;
    end else if (busy_r != 3'd0) begin
      busy_r <= busy_r - 3'd1;
    end
  end

  // effective values with zero and range fallbacks
  always_comb begin
    w_eff   = (width_r == '0) ? DIM_W'(1) : width_r;
    h_eff   = (height_r == '0) ? DIM_W'(1) : height_r;
    area    = AREA_W'(w_eff) * AREA_W'(h_eff);
    pct_eff = (pct_r == '0 || pct_r > PCT_MAX) ? DEF_PERCENT : pct_r;
    x_nxt   = X_W'(total_r) * X_W'(pct_eff) + X_W'(CEIL_ADD);
    mul     = M_W'(x_r) * M_W'(RECIP_V);
    rem     = x_d_r - X_W'(q0_r) * X_W'(PCT_DIV);
    req_nxt = (rem >= X_W'(PCT_DIV)) ? q0_r + PIX_W'(1) : q0_r;
  end

  // required count: area, scaled sum, reciprocal estimate, correction
  always_ff @(posedge clk) begin
    total_r <= (area > AREA_W'(MAX_PIXELS)) ? PIX_W'(MAX_PIXELS) : PIX_W'(area);
    x_r     <= x_nxt;
    x_d_r   <= x_r;
    q0_r    <= PIX_W'(mul >> SH);
    req_r   <= req_nxt;
  end

  assign cfg.threshold = (thr_r == '0) ? DEF_THRESHOLD : thr_r;
  assign cfg.enable    = en_r;
  assign total         = total_r;
  assign required      = req_r;
  assign busy          = (busy_r != 3'd0);

endmodule

`default_nettype wire

// ===== rtl/fcd_frame_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcd_frame_store #(
  parameter int ADDR_W = 16
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [ADDR_W-1:0]               addr,
  input  wire logic [fcd_pkg::PIXEL_BITS-1:0]  wdata,
  output logic [fcd_pkg::PIXEL_BITS-1:0]       rdata
);
  import fcd_pkg::*;

  logic [PIXEL_BITS-1:0] mem [2**ADDR_W];
  logic [PIXEL_BITS-1:0] rdata_r;

  // read the old pixel and replace it in the same cycle
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/fcd_change_count.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcd_change_count #(
  parameter int PIX_W = 17
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            item_valid,
  input  wire fcd_pkg::fcd_item_t              item,
  input  wire logic [fcd_pkg::PIXEL_BITS-1:0]  old_px,
  input  wire fcd_pkg::fcd_cfg_t               cfg,
  input  wire logic [PIX_W-1:0]                required,
  input  wire logic                            clear,
  input  wire logic                            out_tready,
  output logic                                 advance,
  output logic                                 out_tvalid,
  output logic                                 out_changed,
  output logic                                 out_no_ref
);
  import fcd_pkg::*;

  logic                  s1_valid_r;
  fcd_item_t             s1_item_r;
  logic [PIX_W-1:0]      cnt_r;
  logic                  out_valid_r;
  logic                  out_changed_r;
  logic                  out_no_ref_r;

  logic [PIXEL_BITS-1:0] diff;
  logic                  hit;
  logic [PIX_W-1:0]      cnt_sum;
  logic                  finish;

  // stage only holds a frame end that finds the result register taken
  assign advance = !(s1_valid_r && s1_item_r.last && out_valid_r && !out_tready);

  // absolute difference and running count
  always_comb begin
    diff    = (s1_item_r.px >= old_px) ? s1_item_r.px - old_px : old_px - s1_item_r.px;
    hit     = s1_item_r.have_prev && (diff >= cfg.threshold);
    cnt_sum = cnt_r + PIX_W'(hit);
    finish  = s1_valid_r && advance && s1_item_r.last;
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      s1_item_r <= item;
    end
  end

  // changed-pixel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (clear) begin
      cnt_r <= '0;
    end else if (s1_valid_r && advance) begin
      cnt_r <= s1_item_r.last ? '0 : cnt_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_changed_r <= !s1_item_r.have_prev || !cfg.enable || (cnt_sum >= required);
      out_no_ref_r  <= !s1_item_r.have_prev;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_changed = out_changed_r;
  assign out_no_ref  = out_no_ref_r;

endmodule

`default_nettype wire

// ===== rtl/frame_change_detector.sv =====
// frame change detector
//
// in_*  : one 8-bit grayscale pixel per word, raster order, frame after frame.
// out_* : one word after the last pixel of each frame: changed and no_reference.
// cfg_* : register writes (width, height, threshold, percent, enable), taken
//         whenever cfg_wr_en is high, meant for times when no frame result is
//         outstanding. A width or height write restarts the frame and drops the
//         stored reference frame.
// Each pixel is compared with the pixel at the same place of the previous
// frame in the frame store and then replaces it.
// Throughput: one pixel per cycle when not stalled; the frame store has one
// read and one write per cycle at the same address.
// out_tvalid rises once the last pixel has gone through the compare stage.
// After reset and after each write to a known register index in_tready stays
// low while the required changed count runs through its multiply pipeline.
// When out_tready is low the result word holds; pixels keep flowing until a
// second frame end reaches the compare stage, which then stalls in_tready.
// The frame store has no reset; the first frame after reset or a size write
// is reported with no_reference set.
`timescale 1ns / 1ps
`default_nettype none

module frame_change_detector #(
  parameter int MAX_PIXELS = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // pixel [7:0]
  input  wire logic [7:0]                     in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // changed [0], no_reference [1], zeros [7:2]
  output logic [7:0]                          out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_wr_en,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcd_pkg::DIM_W-1:0]      cfg_wdata
);
  import fcd_pkg::*;

  localparam int PIX_W  = $clog2(MAX_PIXELS + 1);
  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  fcd_cfg_t              cfg;
  fcd_item_t             item;
  logic [PIX_W-1:0]      total;
  logic [PIX_W-1:0]      required;
  logic                  size_wr;
  logic                  busy;
  logic                  advance;
  logic                  accept;
  logic                  last;
  logic [PIXEL_BITS-1:0] old_px;
  logic                  out_changed;
  logic                  out_no_ref;

  logic [ADDR_W-1:0]     pos_r;
  logic                  have_prev_r;

  fcd_cfg_regs #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .total     (total),
    .required  (required),
    .size_wr   (size_wr),
    .busy      (busy)
  );

  // handshake and frame position
  assign in_tready = !busy && advance;
  assign accept    = in_tvalid && in_tready;
  assign last      = (PIX_W'(pos_r) + PIX_W'(1)) >= total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      have_prev_r <= 1'b0;
    end else if (size_wr) begin
      pos_r       <= '0;
      have_prev_r <= 1'b0;
    end else if (accept) begin
      pos_r <= last ? '0 : pos_r + ADDR_W'(1);
      if (last) begin
        have_prev_r <= 1'b1;
      end
    end
  end

  fcd_frame_store #(
    .ADDR_W (ADDR_W)
  ) u_frame_store (
    .clk   (clk),
    .en    (accept),
    .addr  (pos_r),
    .wdata (in_tdata[PIXEL_BITS-1:0]),
    .rdata (old_px)
  );

  assign item.px        = in_tdata[PIXEL_BITS-1:0];
  assign item.have_prev = have_prev_r;
  assign item.last      = last;

  fcd_change_count #(
    .PIX_W (PIX_W)
  ) u_change_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (accept),
    .item        (item),
    .old_px      (old_px),
    .cfg         (cfg),
    .required    (required),
    .clear       (size_wr),
    .out_tready  (out_tready),
    .advance     (advance),
    .out_tvalid  (out_tvalid),
    .out_changed (out_changed),
    .out_no_ref  (out_no_ref)
  );

  assign out_tdata = {6'b0, out_no_ref, out_changed};

endmodule

`default_nettype wire

// ===== rtl/fcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic [7:0]                     out_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic                           cfg_wr_en,
  input wire logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index
);
  import fcd_pkg::*;

  logic known_wr;

  assign known_wr = cfg_wr_en &&
                    (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
                     cfg_index == CFG_DIFF_THRESHOLD || cfg_index == CFG_CHANGED_PERCENT ||
                     cfg_index == CFG_DETECT_ENABLE);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // a missing reference frame always counts as a change
  a_noref_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[1] || out_tdata[0]))
    else $error("no_reference without changed");

  // required count settles before pixels are taken again
  a_reset_holdoff: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("pixel taken right after reset");

  a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    known_wr |=> !in_tready)
    else $error("pixel taken right after a register write");

endmodule

bind frame_change_detector fcd_checker u_fcd_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fcd_pkg::*;

  localparam int FRAME_STORE   = 65536;
  localparam int SETTLE        = 8;        // result delay plus required-count pipeline
  localparam int LONG_HOLD     = 150;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int RANDOM_FRAMES = 48;
  localparam int QUIET_FROM    = 1100;
  localparam int MAX_RAND_LEN  = 96;
  localparam int LIMIT_NS      = 30_000_000;

  // verdict for one finished frame
  typedef struct packed {
    logic no_ref;
    logic changed;
  } frame_verdict_t;

  // frame difference predictor and queue of frame verdicts still owed
  class frame_scoreboard;
    logic [PIXEL_BITS-1:0] last_frame [FRAME_STORE];
    bit                    have_ref;
    int unsigned           position;
    int unsigned           changed_count;
    int unsigned           changed_needed;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [THR_W-1:0]      threshold;
    logic [PCT_W-1:0]      percent;
    logic                  enable;
    frame_verdict_t        pending[$];
    int unsigned           mismatches;
    int unsigned           frames_done;
    int unsigned           frames_checked;

    function new();
      width          = RST_WIDTH;
      height         = RST_HEIGHT;
      threshold      = DEF_THRESHOLD;
      percent        = DEF_PERCENT;
      enable         = 1'b1;
      have_ref       = 1'b0;
      position       = 0;
      changed_count  = 0;
      mismatches     = 0;
      frames_done    = 0;
      frames_checked = 0;
      update_needed();
    endfunction

    // pixels per frame, zero sizes taken as one, capped at the store size
    function int unsigned frame_len();
      longint unsigned w;
      longint unsigned h;
      longint unsigned n;
      w = (width == '0) ? 1 : width;
      h = (height == '0) ? 1 : height;
      n = w * h;
      if (n > FRAME_STORE) n = FRAME_STORE;
      return int'(n);
    endfunction

    function int unsigned eff_threshold();
      return (threshold == '0) ? DEF_THRESHOLD : threshold;
    endfunction

    function int unsigned eff_percent();
      return (percent == '0 || percent > PCT_MAX) ? DEF_PERCENT : percent;
    endfunction

    // ceil(pixels * percent / 100)
    function void update_needed();
      changed_needed = (frame_len() * eff_percent() + CEIL_ADD) / PCT_DIV;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
          if (idx == CFG_FRAME_WIDTH) width = val;
          else height = val;
          // size change drops the reference and restarts the frame
          have_ref      = 1'b0;
          position      = 0;
          changed_count = 0;
        end
        CFG_DIFF_THRESHOLD:  threshold = val[THR_W-1:0];
        CFG_CHANGED_PERCENT: percent = val[PCT_W-1:0];
        CFG_DETECT_ENABLE:   enable = val[0];
        default:             return;
      endcase
      update_needed();
    endfunction

    function void note_pixel(logic [PIXEL_BITS-1:0] px);
      int unsigned    total;
      int             a;
      int             b;
      int             diff;
      frame_verdict_t v;
      total = frame_len();
      if (position >= total) position = 0;
      if (have_ref) begin
        a = px;
        b = last_frame[position];
        diff = (a >= b) ? a - b : b - a;
        if (diff >= int'(eff_threshold())) changed_count++;
      end
      last_frame[position] = px;
      position++;
      if (position < total) return;
      // frame end
      v.no_ref  = !have_ref;
      v.changed = !have_ref || !enable || (changed_count >= changed_needed);
      pending.push_back(v);
      frames_done++;
      have_ref      = 1'b1;
      position      = 0;
      changed_count = 0;
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_result(logic [7:0] word);
      frame_verdict_t want;
      if (pending.size() == 0) begin
        log_mismatch($sformatf("result word %h with no frame pending", word));
        return;
      end
      want = pending.pop_front();
      if (word[0] !== want.changed || word[1] !== want.no_ref || word[7:2] !== '0)
        log_mismatch($sformatf("frame %0d: expected changed=%0b no_reference=%0b, got word %h",
                               frames_checked, want.changed, want.no_ref, word));
      frames_checked++;
    endfunction

    function void close_out();
      if (pending.size() != 0)
        log_mismatch($sformatf("%0d frame results never arrived", pending.size()));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [7:0]            in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]      cfg_wdata = '0;

  frame_scoreboard sb;
  bit              idle_on = 1'b1;
  bit              long_hold_req = 1'b0;
  int unsigned     random_items;

  frame_change_detector #(
    .MAX_PIXELS(FRAME_STORE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // pixel close to the stored one, either across or under the threshold, or random as noise
  function automatic logic [7:0] pick_pixel(input int change_pct, input int noise_pct);
    int prev;
    int step;
    int thr;
    int v;
    if (!sb.have_ref || int'($urandom_range(0, 99)) < noise_pct) return 8'($urandom);
    prev = sb.last_frame[sb.position];
    thr  = sb.eff_threshold();
    if (int'($urandom_range(0, 99)) < change_pct)
      step = thr + int'($urandom_range(0, 3)) - int'($urandom_range(0, 3) == 0);
    else
      step = int'($urandom_range(0, thr - 1));
    if ($urandom_range(0, 1) == 1 && prev + step <= 255) v = prev + step;
    else if (prev >= step) v = prev - step;
    else if (prev + step <= 255) v = prev + step;
    else v = ($urandom_range(0, 1) == 1) ? 255 : 0;
    return 8'(v);
  endfunction

  // offer one pixel word, maybe after a short gap, and wait for it to be taken
  task automatic send_pixel(input logic [7:0] px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata  <= px;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
  endtask

  // register write; caller drops cfg_wr_en after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // stop sending, wait for every owed result, then let the pipeline go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_config();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] val;
    // frame size
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = DIM_W'($urandom_range(1024, 2047));
        default: w = DIM_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
        0:       h = '0;
        1:       h = DIM_W'($urandom_range(1024, 2047));
        default: h = DIM_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 2))
        0:       write_reg(CFG_FRAME_WIDTH, w);
        1:       write_reg(CFG_FRAME_HEIGHT, h);
        default: begin
          write_reg(CFG_FRAME_HEIGHT, h);
          write_reg(CFG_FRAME_WIDTH, w);
        end
      endcase
    end
    // keep random frames short
    if (sb.frame_len() > MAX_RAND_LEN) begin
      write_reg(CFG_FRAME_WIDTH, DIM_W'($urandom_range(1, 16)));
      write_reg(CFG_FRAME_HEIGHT, DIM_W'($urandom_range(1, 6)));
    end
    // threshold, unused upper bits random
    if ($urandom_range(0, 2) == 0) begin
      val = DIM_W'($urandom);
      case ($urandom_range(0, 5))
        0:       val[THR_W-1:0] = '0;
        1:       val[THR_W-1:0] = '1;
        default: val[THR_W-1:0] = THR_W'($urandom_range(1, 255));
      endcase
      write_reg(CFG_DIFF_THRESHOLD, val);
    end
    // percent, including out-of-range values
    if ($urandom_range(0, 2) == 0) begin
      val = DIM_W'($urandom);
      case ($urandom_range(0, 6))
        0:       val[PCT_W-1:0] = '0;
        1:       val[PCT_W-1:0] = PCT_MAX;
        2:       val[PCT_W-1:0] = PCT_W'($urandom_range(101, 127));
        default: val[PCT_W-1:0] = PCT_W'($urandom_range(1, 100));
      endcase
      write_reg(CFG_CHANGED_PERCENT, val);
    end
    if ($urandom_range(0, 3) == 0) begin
      val    = DIM_W'($urandom);
      val[0] = ($urandom_range(0, 3) != 0);
      write_reg(CFG_DETECT_ENABLE, val);
    end
    // index past the register list
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_DETECT_ENABLE) + 1, (1 << CFG_IDX_W) - 1)),
                DIM_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // whole frames of random content, sometimes ending mid-frame
  task automatic random_phase();
    int unsigned len;
    int unsigned count;
    int          change_pct;
    int          noise_pct;
    random_config();
    len   = sb.frame_len();
    count = $urandom_range(1, (len > 256) ? 2 : 4) * len;
    if (len > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, len - 1);
    if ($urandom_range(0, 3) == 0) change_pct = $urandom_range(0, 100);
    else change_pct = int'(sb.eff_percent()) + int'($urandom_range(0, 20)) - 10;
    if (change_pct < 0) change_pct = 0;
    noise_pct = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 100)) : 2;
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(change_pct, noise_pct));
    random_items += count;
    drain();
  endtask

  // result side: random short stalls, one long hold on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned frames_base;
    int          pc;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single-pixel frames with reset threshold and percent
    write_reg(CFG_FRAME_WIDTH, DIM_W'(1));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(1));
    cfg_wr_en <= 1'b0;
    send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd255);
    send_pixel(8'd231); send_pixel(8'd232);
    drain();

    // top threshold and full percent
    write_reg(CFG_DIFF_THRESHOLD, DIM_W'(255));
    write_reg(CFG_CHANGED_PERCENT, DIM_W'(100));
    cfg_wr_en <= 1'b0;
    send_pixel(8'd0); send_pixel(8'd255);
    drain();

    // detection off still reports changed
    write_reg(CFG_DETECT_ENABLE, DIM_W'(0));
    cfg_wr_en <= 1'b0;
    send_pixel(8'd255);
    drain();

    // zero width falls back to one, zero threshold and zero percent to the defaults
    write_reg(CFG_FRAME_WIDTH, DIM_W'(0));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(2));
    write_reg(CFG_DIFF_THRESHOLD, DIM_W'(0));
    write_reg(CFG_CHANGED_PERCENT, DIM_W'(0));
    write_reg(CFG_DETECT_ENABLE, DIM_W'(1));
    cfg_wr_en <= 1'b0;
    send_pixel(8'd10); send_pixel(8'd20); send_pixel(8'd34); send_pixel(8'd20);
    drain();

    // percent above range, then a size write in the middle of a frame
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(3));
    write_reg(CFG_CHANGED_PERCENT, DIM_W'(127));
    cfg_wr_en <= 1'b0;
    send_pixel(8'd1); send_pixel(8'd2);
    drain();
    write_reg(CFG_FRAME_WIDTH, DIM_W'(2));
    cfg_wr_en <= 1'b0;
    for (int i = 0; i < 6; i++) send_pixel(8'd0);
    drain();

    // result side held off while one-pixel frames keep coming
    write_reg(CFG_FRAME_WIDTH, DIM_W'(1));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(1));
    cfg_wr_en <= 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_pixel(pick_pixel(50, 10));
    drain();

    // oversized size registers capped at the store size, start of a frame only
    write_reg(CFG_FRAME_WIDTH, DIM_W'(1024));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(2047));
    write_reg(CFG_CHANGED_PERCENT, DIM_W'($urandom_range(1, 100)));
    cfg_wr_en <= 1'b0;
    pc = int'(sb.eff_percent()) + int'($urandom_range(0, 4)) - 2;
    for (int i = 0; i < 40; i++) send_pixel(pick_pixel(pc, 1));
    drain();

    // random frames, no idling near the end
    random_items = 0;
    frames_base  = sb.frames_done;
    while (random_items < RANDOM_ITEMS || sb.frames_done - frames_base < RANDOM_FRAMES) begin
      idle_on = (random_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      random_phase();
    end

    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
